>>> src/sbpp_pkg.sv
// Shared types and constants for the shot boundary peak picker.
// Used by the ring RAM and by the top level; depends on nothing.
package sbpp_pkg;

    localparam int ScoreW = 24;
    localparam int BitPosW = $clog2(ScoreW);

    localparam logic [1:0] OP_FRAME   = 2'd0;
    localparam logic [1:0] OP_DRAIN   = 2'd1;
    localparam logic [1:0] OP_END     = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [1:0] REG_FACTOR    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_GAP       = 2'd2;

    typedef struct packed {
        logic [31:0] frame;
        logic [31:0] ms;
    } frame_id_t;

    typedef struct packed {
        logic [ScoreW-1:0] score;
        frame_id_t         ctr;
    } ring_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAME,
        S_PUSH,
        S_WRITE,
        S_MED_INIT,
        S_SCAN,
        S_BIT,
        S_CTR_RD,
        S_DECIDE,
        S_EMIT
    } state_t;

endpackage

>>> src/shot_boundary_peak_picker_top.sv
// Shot boundary peak picker top level: control sequencer, frame window,
// median selection over the score ring. Depends on sbpp_pkg, sbpp_ring_ram.
//
// Usage: one input item (operation, frame_number, frame_time_ms, cut_score)
// is accepted when in_valid is high and in_stall is low; a shot record is
// offered on the output ports with out_valid and taken when out_stall is low.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle,
// which the block does not enforce: index 0 peak factor, 1 score threshold, 2 gap limit.
// Sequence: a new-frame or drain item runs a bitwise rank selection for the
// median: 24 passes, each reading the n live ring entries from the ring RAM
// at one read per cycle, then a centre read and the decision. A drain skips
// the frame, push and write steps; a frame that closes a shot on a gap runs
// no selection; a shot adds the emit step. End-of-stream items and drains
// that leave the ring empty run no selection either. in_stall is low only
// while the sequencer is idle.
// The result sits in an output register, so the next item is accepted while
// it waits; a later result holds the sequencer until the register frees.
// Reset clears all control state and loads the register defaults; ring RAM
// contents need no clearing since only entries below the fill count are read.
module shot_boundary_peak_picker_top
    import sbpp_pkg::*;
#(
    parameter int FRAME_WINDOW = 9,
    parameter int SCORE_WINDOW = 72
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [31:0]       frame_number,
    input  logic [31:0]       frame_time_ms,
    input  logic [ScoreW-1:0] cut_score,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       shot_number,
    output logic [31:0]       first_frame,
    output logic [31:0]       last_frame,
    output logic [31:0]       mid_frame,
    output logic [31:0]       start_ms,
    output logic [31:0]       end_ms,
    output logic [31:0]       middle_ms,
    output logic [ScoreW-1:0] peak_score,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data
);

    localparam int FAW = (FRAME_WINDOW > 1) ? $clog2(FRAME_WINDOW) : 1;
    localparam int FCW = $clog2(FRAME_WINDOW + 1);
    localparam int AW  = $clog2(SCORE_WINDOW);
    localparam int CW  = $clog2(SCORE_WINDOW + 1);
    localparam logic [FCW:0] FwVal = (FCW + 1)'(FRAME_WINDOW);
    localparam logic [CW:0]  SwVal = (CW + 1)'(SCORE_WINDOW);

    state_t state_reg, state_next;
    state_t after_reg, after_next;

    logic [3:0]        factor_reg;
    logic [ScoreW-1:0] thr_reg;
    logic [15:0]       gap_reg;

    frame_id_t         cur_reg;
    logic [ScoreW-1:0] score_in_reg;

    frame_id_t         recent_reg [FRAME_WINDOW];
    logic [FAW-1:0]    rhead_reg, rhead_next;
    logic [FCW-1:0]    rcount_reg, rcount_next;

    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     wpos_reg, wpos_next;
    logic              decide_reg, decide_next;

    logic              in_peak_reg, in_peak_next;
    logic [ScoreW-1:0] peak_val_reg, peak_val_next;
    frame_id_t         peak_frm_reg, peak_frm_next;
    frame_id_t         start_reg, start_next;
    frame_id_t         prev_reg, prev_next;
    logic              seen0_reg, seen0_next;
    logic              seen1_reg, seen1_next;
    logic [31:0]       counter_reg, counter_next;

    // rank selection
    logic [ScoreW-1:0] prefix_reg, prefix_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [AW-1:0]     saddr_reg, saddr_next;
    logic [BitPosW-1:0] bit_reg, bit_next;
    logic              pend_reg, pend_next;

    // pending record
    frame_id_t         ea_reg, ea_next;
    frame_id_t         eb_reg, eb_next;
    logic [ScoreW-1:0] ep_reg, ep_next;

    logic              out_valid_reg;
    logic              out_load;

    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    ring_entry_t       ram_wdata;
    ring_entry_t       ram_rdata;

    logic              in_acc;
    logic              recent_we;
    logic [FAW-1:0]    recent_waddr;

    logic [ScoreW-1:0] himask;
    logic              match;
    logic [AW:0]       sum_addr;
    logic [AW-1:0]     next_saddr;
    logic [AW:0]       ctr_sum;
    logic [AW-1:0]     ctr_addr;
    logic [FAW:0]      cidx_sum;
    logic [FAW-1:0]    cidx;
    logic [FAW:0]      rw_sum;
    logic [AW:0]       wp_sum;
    logic [32:0]       diff;
    logic              gap_hit;
    frame_id_t         start_eff;
    logic [3:0]        fac;
    logic [27:0]       med_fac;
    logic [24:0]       med_two;
    logic              open_pk;
    logic              pk_in;
    logic [ScoreW-1:0] pv;
    frame_id_t         pfr;
    logic              close_pk;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    sbpp_ring_ram #(
        .DEPTH (SCORE_WINDOW),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // address helpers, scan match, gap and factor terms; address operands stay below twice the window
    always_comb
    begin
        sum_addr = {1'b0, saddr_reg} + (AW + 1)'(1);
        next_saddr = (sum_addr >= (AW + 1)'(SCORE_WINDOW))
                     ? AW'(sum_addr - (AW + 1)'(SCORE_WINDOW)) : sum_addr[AW-1:0];
        ctr_sum = {1'b0, head_reg} + (AW + 1)'(count_reg >> 1);
        ctr_addr = (ctr_sum >= (AW + 1)'(SCORE_WINDOW))
                   ? AW'(ctr_sum - (AW + 1)'(SCORE_WINDOW)) : ctr_sum[AW-1:0];
        cidx_sum = (FAW + 1)'(rhead_reg) + (FAW + 1)'(rcount_reg >> 1);
        cidx = (cidx_sum >= (FAW + 1)'(FRAME_WINDOW))
               ? FAW'(cidx_sum - (FAW + 1)'(FRAME_WINDOW)) : cidx_sum[FAW-1:0];
        rw_sum = (FAW + 1)'(rhead_reg) + (FAW + 1)'(rcount_reg);
        wp_sum = {1'b0, head_reg} + (AW + 1)'(count_reg);
        himask = ({ScoreW{1'b1}} << bit_reg) << 1;
        match = (((ram_rdata.score ^ prefix_reg) & himask) == '0)
                && !ram_rdata.score[bit_reg];
        diff = {1'b0, cur_reg.frame} - {1'b0, prev_reg.frame};
        gap_hit = seen1_reg && !diff[32] && (diff > {17'b0, gap_reg});
        start_eff = seen0_reg ? start_reg : cur_reg;
        fac = (factor_reg == 4'd0) ? 4'd1 : factor_reg;
    end

    // decision on the centre entry
    always_comb
    begin
        med_fac = 28'(prefix_reg) * 28'(fac);
        med_two = {prefix_reg, 1'b0};
        open_pk = !in_peak_reg && (28'(ram_rdata.score) > med_fac)
                  && (ram_rdata.score > thr_reg);
        pk_in = in_peak_reg || open_pk;
        pv  = open_pk ? ram_rdata.score : peak_val_reg;
        pfr = open_pk ? ram_rdata.ctr : peak_frm_reg;
        if (pk_in && (ram_rdata.score > pv))
        begin
            pv  = ram_rdata.score;
            pfr = ram_rdata.ctr;
        end
        close_pk = pk_in && ((25'(ram_rdata.score) <= med_two)
                   || (ram_rdata.score < thr_reg));
    end

    always_comb
    begin
        state_next    = state_reg;
        after_next    = after_reg;
        rhead_next    = rhead_reg;
        rcount_next   = rcount_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        wpos_next     = wpos_reg;
        decide_next   = decide_reg;
        in_peak_next  = in_peak_reg;
        peak_val_next = peak_val_reg;
        peak_frm_next = peak_frm_reg;
        start_next    = start_reg;
        prev_next     = prev_reg;
        seen0_next    = seen0_reg;
        seen1_next    = seen1_reg;
        counter_next  = counter_reg;
        prefix_next   = prefix_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        j_next        = j_reg;
        saddr_next    = saddr_reg;
        bit_next      = bit_reg;
        pend_next     = 1'b0;
        ea_next       = ea_reg;
        eb_next       = eb_reg;
        ep_next       = ep_reg;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_raddr     = saddr_reg;
        ram_wdata.score = score_in_reg;
        ram_wdata.ctr   = recent_reg[cidx];
        recent_we     = 1'b0;
        recent_waddr  = rhead_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (operation == OP_FRAME)
                    begin
                        state_next = S_FRAME;
                    end
                    else if (operation == OP_DRAIN)
                    begin
                        if (count_reg != '0)
                        begin
                            head_next = (head_reg == AW'(SCORE_WINDOW - 1))
                                        ? '0 : head_reg + AW'(1);
                            count_next = count_reg - CW'(1);
                            if (count_reg != CW'(1))
                            begin
                                state_next = S_MED_INIT;
                            end
                        end
                    end
                    else if (operation == OP_END)
                    begin
                        if (seen1_reg)
                        begin
                            seen0_next = 1'b1;
                            start_next = prev_reg;
                            if (seen0_reg && (start_reg != prev_reg))
                            begin
                                peak_frm_next = prev_reg;
                                ea_next    = start_reg;
                                eb_next    = prev_reg;
                                ep_next    = peak_val_reg;
                                after_next = S_IDLE;
                                state_next = S_EMIT;
                            end
                        end
                    end
                    else
                    begin
                        // unused operation code: item is dropped
                        state_next = S_IDLE;
                    end
                end
            end
            S_FRAME:
            begin
                seen0_next = 1'b1;
                if (gap_hit)
                begin
                    peak_frm_next = prev_reg;
                    ea_next      = start_eff;
                    eb_next      = prev_reg;
                    ep_next      = peak_val_reg;
                    start_next   = cur_reg;
                    rhead_next   = '0;
                    rcount_next  = '0;
                    head_next    = '0;
                    count_next   = '0;
                    in_peak_next = 1'b0;
                    peak_val_next = '0;
                    decide_next  = 1'b0;
                    after_next   = S_PUSH;
                    state_next   = S_EMIT;
                end
                else
                begin
                    start_next  = start_eff;
                    decide_next = 1'b1;
                    state_next  = S_PUSH;
                end
            end
            S_PUSH:
            begin
                recent_we = 1'b1;
                if ((FCW + 1)'(rcount_reg) < FwVal)
                begin
                    recent_waddr = (rw_sum >= (FAW + 1)'(FRAME_WINDOW))
                                   ? FAW'(rw_sum - (FAW + 1)'(FRAME_WINDOW))
                                   : rw_sum[FAW-1:0];
                    rcount_next = rcount_reg + FCW'(1);
                end
                else
                begin
                    rhead_next = (rhead_reg == FAW'(FRAME_WINDOW - 1))
                                 ? '0 : rhead_reg + FAW'(1);
                end
                prev_next  = cur_reg;
                seen1_next = 1'b1;
                if ((CW + 1)'(count_reg) < SwVal)
                begin
                    wpos_next = (wp_sum >= (AW + 1)'(SCORE_WINDOW))
                                ? AW'(wp_sum - (AW + 1)'(SCORE_WINDOW)) : wp_sum[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    wpos_next = head_reg;
                    head_next = (head_reg == AW'(SCORE_WINDOW - 1))
                                ? '0 : head_reg + AW'(1);
                end
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                state_next = decide_reg ? S_MED_INIT : S_IDLE;
            end
            S_MED_INIT:
            begin
                prefix_next = '0;
                k_next      = count_reg >> 1;
                cnt_next    = '0;
                j_next      = '0;
                saddr_next  = head_reg;
                bit_next    = BitPosW'(ScoreW - 1);
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (pend_reg && match)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (j_reg != count_reg)
                begin
                    pend_next  = 1'b1;
                    j_next     = j_reg + CW'(1);
                    saddr_next = next_saddr;
                end
                else if (!pend_reg)
                begin
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                if (k_reg >= cnt_reg)
                begin
                    prefix_next = prefix_reg | (ScoreW'(1) << bit_reg);
                    k_next      = k_reg - cnt_reg;
                end
                if (bit_reg == '0)
                begin
                    state_next = S_CTR_RD;
                end
                else
                begin
                    bit_next   = bit_reg - BitPosW'(1);
                    cnt_next   = '0;
                    j_next     = '0;
                    saddr_next = head_reg;
                    state_next = S_SCAN;
                end
            end
            S_CTR_RD:
            begin
                ram_raddr  = ctr_addr;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                in_peak_next  = pk_in && !close_pk;
                peak_val_next = pv;
                peak_frm_next = pfr;
                state_next    = S_IDLE;
                if (close_pk)
                begin
                    ea_next    = start_reg;
                    eb_next    = pfr;
                    ep_next    = pv;
                    start_next = pfr;
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load     = 1'b1;
                    counter_next = counter_reg + 32'd1;
                    state_next   = after_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            after_reg     <= S_IDLE;
            factor_reg    <= 4'd2;
            thr_reg       <= ScoreW'(65536);
            gap_reg       <= 16'd10;
            rhead_reg     <= '0;
            rcount_reg    <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            decide_reg    <= 1'b0;
            in_peak_reg   <= 1'b0;
            peak_val_reg  <= '0;
            peak_frm_reg  <= '0;
            start_reg     <= '0;
            prev_reg      <= '0;
            seen0_reg     <= 1'b0;
            seen1_reg     <= 1'b0;
            counter_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            after_reg    <= after_next;
            rhead_reg    <= rhead_next;
            rcount_reg   <= rcount_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            decide_reg   <= decide_next;
            in_peak_reg  <= in_peak_next;
            peak_val_reg <= peak_val_next;
            peak_frm_reg <= peak_frm_next;
            start_reg    <= start_next;
            prev_reg     <= prev_next;
            seen0_reg    <= seen0_next;
            seen1_reg    <= seen1_next;
            counter_reg  <= counter_next;
            pend_reg     <= pend_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FACTOR:    factor_reg <= cfg_data[3:0];
                    REG_THRESHOLD: thr_reg    <= cfg_data[ScoreW-1:0];
                    REG_GAP:       gap_reg    <= cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_reg      <= '{frame: frame_number, ms: frame_time_ms};
            score_in_reg <= cut_score;
        end
        if (recent_we)
        begin
            recent_reg[recent_waddr] <= cur_reg;
        end
        wpos_reg   <= wpos_next;
        prefix_reg <= prefix_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        j_reg      <= j_next;
        saddr_reg  <= saddr_next;
        bit_reg    <= bit_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        ep_reg     <= ep_next;
        if (out_load)
        begin
            shot_number  <= counter_reg;
            first_frame  <= ea_reg.frame;
            last_frame   <= eb_reg.frame;
            mid_frame    <= 32'(({1'b0, ea_reg.frame} + {1'b0, eb_reg.frame}) >> 1);
            start_ms     <= ea_reg.ms;
            end_ms       <= eb_reg.ms;
            middle_ms    <= 32'(({1'b0, ea_reg.ms} + {1'b0, eb_reg.ms}) >> 1);
            peak_score   <= ep_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(count_reg) <= SwVal)
        else $error("ring fill count beyond window");

    a_recent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (FCW + 1)'(rcount_reg) <= FwVal)
        else $error("frame window count beyond window");

    a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg < count_reg))
        else $error("median rank outside live entries");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("shot record offered without an emit step");

    a_decide_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MED_INIT) |-> (count_reg != '0))
        else $error("decision started on an empty ring");

endmodule

>>> src/sbpp_ring_ram.sv
// Simple dual-port synchronous RAM (one write port, one registered read port) holding the score / centre-frame ring.
// Depends on sbpp_pkg for the entry type.
module sbpp_ring_ram
    import sbpp_pkg::*;
#(
    parameter int DEPTH = 72,
    parameter int AW = 7
)
(
    input  logic        clk,
    input  logic        we,
    input  logic [AW-1:0] waddr,
    input  ring_entry_t wdata,
    input  logic [AW-1:0] raddr,
    output ring_entry_t rdata
);

    ring_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
